/* hw/rtl/rate_monotonic_tick_scheduler_top_defines.svh */
// Assertion macros used by the checker file.
`ifndef RATE_MONOTONIC_TICK_SCHEDULER_TOP_DEFINES_SVH
`define RATE_MONOTONIC_TICK_SCHEDULER_TOP_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define RMTS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("rmts assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RMTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("rmts assertion failed");

`endif

/* hw/rtl/rmts_pkg.sv */
package rmts_pkg;

  localparam int unsigned MaxSlots = 8;
  localparam int unsigned SlotIdxW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
  localparam int unsigned OpW      = 2;
  localparam int unsigned SlotW    = 3;
  localparam int unsigned PeriodW  = 16;
  localparam int unsigned BudgetW  = 16;
  localparam int unsigned ActW     = 4;
  localparam int unsigned TimeW    = 32;

  typedef enum logic [OpW-1:0] {
    OP_TICK    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef struct packed {
    logic                found;
    logic [SlotIdxW-1:0] idx;
  } winner_t;

  typedef struct packed {
    logic             busy;
    logic [SlotW-1:0] slot;
    logic [TimeW-1:0] tick_time;
  } result_t;

endpackage

/* hw/rtl/rate_monotonic_tick_scheduler_top.sv */
// Rate-monotonic tick scheduler over eight task slots.
// Requests arrive on the s_axis channel: tuser carries the op (tick, write slot,
// restart), tdata the slot, period and budget of a write. A tick request yields
// one result on m_axis: tuser is the busy flag, tdata the running slot and the
// tick number taken before this tick's advance. Write and restart requests
// yield no result. cfg_we_i/cfg_wdata_i set the number of active slots; write
// it only while no request is in flight.
// A request sits in the input register after its acceptance, and a tick's
// result is loaded into the output register as the request leaves it,
// raising m_axis_tvalid. Throughput is one request per cycle while no tick
// waits behind a stalled result; the release checks and the shortest-period
// pick over all slots are one combinational pass between the input and output registers.
// Reset clears every period, budget, phase and remaining counter, the tick
// count and the active slot count, and empties both registers.
// When the receiver stalls, the pending result is held and s_axis_tready
// stays high until a tick request waits behind it; writes and restarts
// still pass the stalled result.
module rate_monotonic_tick_scheduler_top import rmts_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [39:0]     s_axis_tdata,  // slot[2:0], task_period[18:3], task_budget[34:19]
  input  logic [OpW-1:0]  s_axis_tuser,  // op[1:0]
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [39:0]     m_axis_tdata,  // running_slot[2:0], tick_time[34:3]
  output logic            m_axis_tuser,  // busy_res[0]
  input  logic            cfg_we_i,
  input  logic [ActW-1:0] cfg_wdata_i
);

  logic               in_valid_q, in_valid_d;
  logic [OpW-1:0]     in_op_q;
  logic [SlotW-1:0]   in_slot_q;
  logic [PeriodW-1:0] in_period_q;
  logic [BudgetW-1:0] in_budget_q;
  logic               out_valid_q, out_valid_d;
  result_t            out_res_q;
  logic [ActW-1:0]    active_q;
  logic               is_tick;
  logic               advance;
  logic               s_take;
  result_t            res;

  assign is_tick       = (in_op_q == OP_TICK);
  assign advance       = in_valid_q && (!is_tick || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_take        = s_axis_tvalid && s_axis_tready;

  rmts_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .op_i           (in_op_q),
    .slot_i         (in_slot_q),
    .period_i       (in_period_q),
    .budget_i       (in_budget_q),
    .active_tasks_i (active_q),
    .res_o          (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance && is_tick) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      active_q    <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_op_q     <= s_axis_tuser;
      in_slot_q   <= s_axis_tdata[2:0];
      in_period_q <= s_axis_tdata[18:3];
      in_budget_q <= s_axis_tdata[34:19];
    end
    if (advance && is_tick) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.busy;
  assign m_axis_tdata  = {5'b0, out_res_q.tick_time, out_res_q.slot};

endmodule

/* hw/rtl/rmts_select.sv */
module rmts_select import rmts_pkg::*; (
  input  logic [MaxSlots-1:0]              elig_i,
  input  logic [MaxSlots-1:0][PeriodW-1:0] period_i,
  output winner_t                          win_o
);

  always_comb begin
    logic [PeriodW-1:0] best_p;
    win_o  = '0;
    best_p = '0;
    for (int unsigned i = 0; i < MaxSlots; i++) begin
      if (elig_i[i] && (!win_o.found || (period_i[i] < best_p))) begin
        win_o.found = 1'b1;
        win_o.idx   = SlotIdxW'(i);
        best_p      = period_i[i];
      end
    end
  end

endmodule

/* hw/rtl/rmts_core.sv */
module rmts_core import rmts_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [OpW-1:0]     op_i,
  input  logic [SlotW-1:0]   slot_i,
  input  logic [PeriodW-1:0] period_i,
  input  logic [BudgetW-1:0] budget_i,
  input  logic [ActW-1:0]    active_tasks_i,
  output result_t            res_o
);

  logic [MaxSlots-1:0][PeriodW-1:0] period_q, period_d;
  logic [MaxSlots-1:0][BudgetW-1:0] budget_q, budget_d;
  logic [MaxSlots-1:0][BudgetW-1:0] remain_q, remain_d;
  logic [MaxSlots-1:0][PeriodW-1:0] phase_q, phase_d;
  logic [TimeW-1:0]                 time_q, time_d;

  logic [MaxSlots-1:0]              active;
  logic [MaxSlots-1:0]              elig;
  logic [MaxSlots-1:0][BudgetW-1:0] remain_rl;
  logic [MaxSlots-1:0][PeriodW-1:0] phase_nx;
  winner_t                          win;

  always_comb begin
    logic [PeriodW:0] ph_inc;
    for (int unsigned i = 0; i < MaxSlots; i++) begin
      active[i]    = (period_q[i] != '0) && (32'(i) < 32'(active_tasks_i));
      remain_rl[i] = (active[i] && (phase_q[i] == '0)) ? budget_q[i] : remain_q[i];
      elig[i]      = active[i] && (remain_rl[i] != '0);
      ph_inc       = {1'b0, phase_q[i]} + 1'b1;
      if ((period_q[i] == '0) || (ph_inc >= {1'b0, period_q[i]})) begin
        phase_nx[i] = '0;
      end else begin
        phase_nx[i] = ph_inc[PeriodW-1:0];
      end
    end
  end

  rmts_select u_select (
    .elig_i   (elig),
    .period_i (period_q),
    .win_o    (win)
  );

  always_comb begin
    period_d = period_q;
    budget_d = budget_q;
    remain_d = remain_q;
    phase_d  = phase_q;
    time_d   = time_q;
    if (step_i) begin
      case (op_i)
        OP_TICK: begin
          for (int unsigned i = 0; i < MaxSlots; i++) begin
            if (win.found && (32'(win.idx) == 32'(i))) begin
              remain_d[i] = remain_rl[i] - 1'b1;
            end else begin
              remain_d[i] = remain_rl[i];
            end
          end
          phase_d = phase_nx;
          time_d  = time_q + 1'b1;
        end
        OP_WRITE: begin
          for (int unsigned i = 0; i < MaxSlots; i++) begin
            if (32'(slot_i) == 32'(i)) begin
              period_d[i] = period_i;
              budget_d[i] = budget_i;
            end
          end
        end
        OP_RESTART: begin
          remain_d = '0;
          phase_d  = '0;
          time_d   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign res_o.busy      = win.found;
  assign res_o.slot      = win.found ? SlotW'(32'(win.idx)) : '0;
  assign res_o.tick_time = time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= '0;
      budget_q <= '0;
      remain_q <= '0;
      phase_q  <= '0;
      time_q   <= '0;
    end else begin
      period_q <= period_d;
      budget_q <= budget_d;
      remain_q <= remain_d;
      phase_q  <= phase_d;
      time_q   <= time_d;
    end
  end

endmodule

/* hw/rtl/rmts_checker.sv */
`include "rate_monotonic_tick_scheduler_top_defines.svh"

module rmts_checker import rmts_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tready,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [39:0]     m_axis_tdata,
  input logic            m_axis_tuser
);

  logic        out_stall;
  logic [40:0] out_bus;
  logic [2:0]  out_slot;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_bus   = {m_axis_tuser, m_axis_tdata};
  assign out_slot  = m_axis_tdata[2:0];

  `RMTS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(out_bus))
  `RMTS_ASSERT(a_idle_slot_zero, clk_i, rst_ni, !m_axis_tvalid || m_axis_tuser || (out_slot == '0))
  `RMTS_ASSERT(a_ready_when_empty, clk_i, rst_ni, m_axis_tvalid || s_axis_tready)

endmodule

bind rate_monotonic_tick_scheduler_top rmts_checker u_rmts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import rmts_pkg::*;

  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam int unsigned NumSlots = MaxSlots;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [39:0]       s_axis_tdata = '0;
  logic [OpW-1:0]    s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [39:0]       m_axis_tdata;
  logic              m_axis_tuser;
  logic              cfg_we_i = 1'b0;
  logic [ActW-1:0]   cfg_wdata_i = '0;

  logic [PeriodW-1:0] period_tab [NumSlots];
  logic [BudgetW-1:0] budget_tab [NumSlots];
  logic [BudgetW-1:0] remain_tab [NumSlots];
  logic [PeriodW-1:0] phase_tab  [NumSlots];
  logic [TimeW-1:0]   tick_count;
  logic [ActW-1:0]    active_cnt;

  result_t sched_expect_q [$];
  int      error_count = 0;
  int      gap_pct = 0;
  int      stall_pct = 0;
  int      stall_left = 0;

  rate_monotonic_tick_scheduler_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(60, 20);
    return $urandom_range(3, 1);
  endfunction

  task automatic clear_schedule();
    for (int i = 0; i < NumSlots; i++) begin
      remain_tab[i] = '0;
      phase_tab[i]  = '0;
    end
    tick_count = '0;
  endtask

  task automatic schedule_request(logic [OpW-1:0] op, logic [SlotW-1:0] slot,
                                  logic [PeriodW-1:0] per, logic [BudgetW-1:0] bud);
    int      lim;
    int      best;
    bit      found;
    int      nxt;
    result_t r;
    case (op)
      OP_WRITE: begin
        period_tab[slot] = per;
        budget_tab[slot] = bud;
      end
      OP_RESTART: clear_schedule();
      OP_TICK: begin
        lim   = (active_cnt > NumSlots) ? NumSlots : int'(active_cnt);
        best  = 0;
        found = 1'b0;
        for (int i = 0; i < NumSlots; i++) begin
          if (period_tab[i] == '0) begin
            phase_tab[i] = '0;
          end else begin
            if (i < lim && phase_tab[i] == '0) remain_tab[i] = budget_tab[i];
            if (i < lim && remain_tab[i] != '0 &&
                (!found || period_tab[i] < period_tab[best])) begin
              best  = i;
              found = 1'b1;
            end
            nxt = int'(phase_tab[i]) + 1;
            phase_tab[i] = (nxt >= int'(period_tab[i])) ? '0 : nxt[PeriodW-1:0];
          end
        end
        if (found) remain_tab[best] = remain_tab[best] - 1'b1;
        r.busy      = found;
        r.slot      = found ? best[SlotW-1:0] : '0;
        r.tick_time = tick_count;
        tick_count  = tick_count + 1'b1;
        sched_expect_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic send_request(logic [OpW-1:0] op, logic [SlotW-1:0] slot,
                              logic [PeriodW-1:0] per, logic [BudgetW-1:0] bud);
    int gap;
    gap = pick_gap(gap_pct);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'b0, bud, per, slot};
    do @(posedge clk_i); while (!s_axis_tready);
    schedule_request(op, slot, per, bud);
    @(negedge clk_i);
  endtask

  task automatic send_ticks(int count);
    for (int k = 0; k < count; k++)
      send_request(OP_TICK, SlotW'($urandom()), PeriodW'($urandom()), BudgetW'($urandom()));
  endtask

  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    while (sched_expect_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_active(logic [ActW-1:0] value);
    wait_all_results();
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= ActW'($urandom());
    active_cnt = value;
  endtask

  task automatic send_random_request();
    int               pick;
    logic [PeriodW-1:0] per;
    logic [BudgetW-1:0] bud;
    pick = $urandom_range(99);
    if ($urandom_range(6) == 0) begin
      per = PeriodW'($urandom());
      bud = BudgetW'($urandom());
    end else begin
      per = PeriodW'($urandom_range(24, 1));
      bud = BudgetW'($urandom_range(6));
      if ($urandom_range(15) == 0) per = '0;
    end
    if (pick < 76)
      send_request(OP_TICK, SlotW'($urandom()), PeriodW'($urandom()), BudgetW'($urandom()));
    else if (pick < 95)
      send_request(OP_WRITE, SlotW'($urandom()), per, bud);
    else if (pick < 98)
      send_request(OP_RESTART, SlotW'($urandom()), PeriodW'($urandom()), BudgetW'($urandom()));
    else
      send_request(OpUnused, SlotW'($urandom()), PeriodW'($urandom()), BudgetW'($urandom()));
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (sched_expect_q.size() == 0) begin
        report_mismatch("unexpected result, tick_time", m_axis_tdata[34:3], -1);
      end else begin
        want = sched_expect_q.pop_front();
        if (m_axis_tuser !== want.busy) report_mismatch("busy", m_axis_tuser, want.busy);
        if (m_axis_tdata[2:0] !== want.slot)
          report_mismatch("running_slot", m_axis_tdata[2:0], want.slot);
        if (m_axis_tdata[34:3] !== want.tick_time)
          report_mismatch("tick_time", m_axis_tdata[34:3], want.tick_time);
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      stall_left = pick_gap(stall_pct);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic test_directed();
    gap_pct   = 0;
    stall_pct = 0;
    set_active(4'd8);
    send_request(OP_WRITE, 3'd0, 16'd1, 16'd1);
    send_ticks(2);
    send_request(OP_WRITE, 3'd7, 16'hffff, 16'hffff);
    send_request(OP_WRITE, 3'd2, 16'd4, 16'd2);
    send_request(OP_WRITE, 3'd4, 16'd3, 16'd1);
    send_request(OP_WRITE, 3'd5, 16'd3, 16'd1);
    send_ticks(3);
    send_request(OP_WRITE, 3'd0, 16'd0, 16'd0);
    send_ticks(4);
    send_request(OpUnused, 3'd6, 16'd5, 16'd5);
    send_request(OP_WRITE, 3'd1, 16'd10, 16'd0);
    send_request(OP_RESTART, 3'd0, 16'd0, 16'd0);
    send_ticks(3);
    send_request(OP_WRITE, 3'd2, 16'd2, 16'd1);
    send_ticks(3);
    set_active(4'd15);
    send_ticks(2);
    set_active(4'd0);
    send_ticks(2);
  endtask

  task automatic test_random_settings();
    logic [ActW-1:0] settings [6] = '{4'd1, 4'd3, 4'd8, 4'd15, 4'd0, 4'd5};
    for (int ph = 0; ph < 6; ph++) begin
      set_active((ph == 5) ? 4'($urandom_range(8)) : settings[ph]);
      gap_pct   = (ph % 3 == 0) ? 0 : 10 + 15 * ph;
      stall_pct = (ph % 2 == 0) ? 0 : 5 + 12 * ph;
      if (ph == 2) begin
        gap_pct   = 35;
        stall_pct = 35;
      end
      send_request(OP_RESTART, SlotW'($urandom()), PeriodW'($urandom()), BudgetW'($urandom()));
      for (int k = 0; k < 290; k++) send_random_request();
    end
  endtask

  task automatic test_backpressure();
    set_active(4'd8);
    gap_pct   = 0;
    stall_pct = 60;
    for (int k = 0; k < 60; k++) send_random_request();
    wait_all_results();
    for (int k = 0; k < 60; k++) send_random_request();
    stall_pct = 0;
  endtask

  initial begin
    for (int i = 0; i < NumSlots; i++) begin
      period_tab[i] = '0;
      budget_tab[i] = '0;
    end
    clear_schedule();
    active_cnt = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_settings();
    test_backpressure();
    wait_all_results();
    repeat (10) @(negedge clk_i);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* rate_monotonic_tick_scheduler_top.f */
+incdir+hw/rtl
hw/rtl/rmts_pkg.sv
hw/rtl/rmts_select.sv
hw/rtl/rmts_core.sv
hw/rtl/rate_monotonic_tick_scheduler_top.sv
hw/rtl/rmts_checker.sv
verif/testbench.sv
